### design/accel_tilt_roll_pitch_assert.svh
// Assertion macros for the accelerometer tilt block.
`ifndef ACCEL_TILT_ROLL_PITCH_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ATRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accel tilt check failed");

// Next-cycle implication, disabled while in reset.
`define ATRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accel tilt check failed");

`endif

### design/atrp_pkg.sv
// Package: constants, arctangent table and shared types of the tilt block.
package atrp_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TAB_SIZE     = 24;

    localparam int GUARD_BITS   = 16;       // fraction bits added to each sample
    localparam int HEADROOM     = 4;        // growth bits for CORDIC gain, twice
    localparam int ANGLE_W      = 25;       // angle accumulator, 2^-15 degree
    localparam int GAIN_Q16     = 107922;   // CORDIC gain, Q16
    localparam int GAIN_W       = 18;
    localparam int QUARTER_TURN = 2949120;  // 90 degrees in accumulator units
    localparam int ROLL_LIMIT   = 23040;
    localparam int PITCH_LIMIT  = 11520;
    localparam int ROUND_SHIFT  = 8;
    localparam int ROLL_W       = 16;
    localparam int PITCH_W      = 15;
    localparam int OUT_DATA_W   = 32;

    typedef struct packed {
        logic special;  // y and z both zero
        logic x_pos;
        logic x_neg;
    } atrp_flags_t;

    localparam int FLAGS_W = $bits(atrp_flags_t);

    // atan(2^-i) in units of 2^-15 degree
    function automatic int atan_entry(input int i);
        int r;
        r = 0;
        unique case (i)
            0:  r = 1474560;
            1:  r = 870484;
            2:  r = 459940;
            3:  r = 233473;
            4:  r = 117189;
            5:  r = 58652;
            6:  r = 29333;
            7:  r = 14667;
            8:  r = 7334;
            9:  r = 3667;
            10: r = 1833;
            11: r = 917;
            12: r = 458;
            13: r = 229;
            14: r = 115;
            15: r = 57;
            16: r = 29;
            17: r = 14;
            18: r = 7;
            19: r = 4;
            20: r = 2;
            21: r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

### design/atrp_front.sv
// Front stage: zero detect, quarter-turn pre-rotation and gain multiply of -x.
module atrp_front #(
    parameter int SAMPLE_WIDTH = atrp_pkg::SAMPLE_WIDTH_DEF,
    parameter int W            = SAMPLE_WIDTH + atrp_pkg::GUARD_BITS + atrp_pkg::HEADROOM
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_x,
    input  logic signed [SAMPLE_WIDTH-1:0] in_y,
    input  logic signed [SAMPLE_WIDTH-1:0] in_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [W-1:0]           out_cx,
    output logic signed [W-1:0]           out_cy,
    output logic signed [atrp_pkg::ANGLE_W-1:0] out_z0,
    output logic signed [W-1:0]           out_py,
    output atrp_pkg::atrp_flags_t         out_flags
);
    import atrp_pkg::*;

    localparam int PW = SAMPLE_WIDTH + GAIN_W + 1;
    localparam logic signed [GAIN_W-1:0]  GAIN = GAIN_W'(GAIN_Q16);
    localparam logic signed [ANGLE_W-1:0] QTR  = ANGLE_W'(QUARTER_TURN);

    logic                    valid_reg;
    logic signed [W-1:0]     cx_reg, cx_next;
    logic signed [W-1:0]     cy_reg, cy_next;
    logic signed [ANGLE_W-1:0] z0_reg, z0_next;
    logic signed [W-1:0]     py_reg, py_next;
    atrp_flags_t             flags_reg, flags_next;

    logic signed [W-1:0]     sy, sz;
    logic signed [SAMPLE_WIDTH:0] nx;
    logic signed [PW-1:0]    prod;

    always_comb
    begin
        sy = W'(in_y) <<< GUARD_BITS;
        sz = W'(in_z) <<< GUARD_BITS;
        nx = -(SAMPLE_WIDTH+1)'(in_x);
        prod = PW'(nx) * PW'(GAIN);
        py_next = W'(prod);

        flags_next.special = (in_y == '0) && (in_z == '0);
        flags_next.x_pos   = !in_x[SAMPLE_WIDTH-1] && (in_x != '0);
        flags_next.x_neg   = in_x[SAMPLE_WIDTH-1];

        if (!in_z[SAMPLE_WIDTH-1])
        begin
            cx_next = sz;
            cy_next = sy;
            z0_next = '0;
        end
        else if (!in_y[SAMPLE_WIDTH-1])
        begin
            cx_next = sy;
            cy_next = -sz;
            z0_next = QTR;
        end
        else
        begin
            cx_next = -sy;
            cy_next = sz;
            z0_next = -QTR;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;
    assign out_z0    = z0_reg;
    assign out_py    = py_reg;
    assign out_flags = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            z0_reg    <= z0_next;
            py_reg    <= py_next;
            flags_reg <= flags_next;
        end
    end

endmodule

### design/atrp_cell.sv
// One vectoring CORDIC micro-rotation, registered, with side payload carried along.
module atrp_cell #(
    parameter int W         = 36,
    parameter int AW        = atrp_pkg::ANGLE_W,
    parameter int SW        = 8,
    parameter int SHIFT     = 0,
    parameter int ATAN_STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  in_x,
    input  logic signed [W-1:0]  in_y,
    input  logic signed [AW-1:0] in_z,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  out_x,
    output logic signed [W-1:0]  out_y,
    output logic signed [AW-1:0] out_z,
    output logic [SW-1:0]        out_side
);

    localparam logic signed [AW-1:0] STEP = AW'(ATAN_STEP);

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic [SW-1:0]        side_reg;
    logic signed [W-1:0]  dx, dy;

    always_comb
    begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        // zero residual turns the positive way
        if (!in_y[W-1])
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + STEP;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - STEP;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

endmodule

### design/accel_tilt_roll_pitch.sv
// Path from accepted sample to result: front register, roll row, pitch row, output register.
// Throughput: one sample per cycle unless m_tready stalls it; two rows of CORDIC cells, each cell one rotation a cycle.
// Every stage has its own valid bit and takes a new word while the one ahead moves on.
// Reset (rst_n low, asynchronous) clears all valid bits; datapath registers are not reset.
// No stored state between samples, so no clearing pass is needed after reset.
// Roll row rotates (z, y); its radius and gain-scaled -x feed the pitch row.
module accel_tilt_roll_pitch #(
    parameter int SAMPLE_WIDTH  = atrp_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = atrp_pkg::CORDIC_STAGES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // slave side, tdata: accel_x, accel_y, accel_z (SAMPLE_WIDTH each), zero-padded to bytes
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // master side, tdata: roll_angle [15:0], pitch_angle [30:16], bit 31 zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [atrp_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import atrp_pkg::*;

    `include "accel_tilt_roll_pitch_assert.svh"

    localparam int N   = (CORDIC_STAGES > ATAN_TAB_SIZE) ? ATAN_TAB_SIZE : CORDIC_STAGES;
    localparam int W   = SAMPLE_WIDTH + GUARD_BITS + HEADROOM;
    localparam int SRW = W + FLAGS_W;        // roll row side: flags, scaled -x
    localparam int SPW = ANGLE_W + FLAGS_W;  // pitch row side: flags, roll angle
    localparam int VW  = ANGLE_W + 1 - ROUND_SHIFT;
    localparam int PADW = OUT_DATA_W - ROLL_W - PITCH_W;

    localparam logic signed [ANGLE_W:0] HALF_LSB   = (ANGLE_W+1)'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [VW-1:0]    ROLL_MAX   = VW'(ROLL_LIMIT);
    localparam logic signed [VW-1:0]    PITCH_MAX  = VW'(PITCH_LIMIT);

    // input fields
    logic signed [SAMPLE_WIDTH-1:0] accel_x, accel_y, accel_z;
    assign accel_x = s_tdata[SAMPLE_WIDTH-1:0];
    assign accel_y = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign accel_z = s_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];

    // front stage
    logic                      f_valid, f_ready;
    logic signed [W-1:0]       f_cx, f_cy, f_py;
    logic signed [ANGLE_W-1:0] f_z0;
    atrp_flags_t               f_flags;

    atrp_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .W            (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (accel_x),
        .in_y      (accel_y),
        .in_z      (accel_z),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cx    (f_cx),
        .out_cy    (f_cy),
        .out_z0    (f_z0),
        .out_py    (f_py),
        .out_flags (f_flags)
    );

    // roll row
    logic                      r_valid [0:N];
    logic                      r_ready [0:N];
    logic signed [W-1:0]       r_x     [0:N];
    logic signed [W-1:0]       r_y     [0:N-1];
    logic signed [ANGLE_W-1:0] r_z     [0:N];
    logic [SRW-1:0]            r_side  [0:N];

    assign r_valid[0] = f_valid;
    assign f_ready    = r_ready[0];
    assign r_x[0]     = f_cx;
    assign r_y[0]     = f_cy;
    assign r_z[0]     = f_z0;
    assign r_side[0]  = {f_flags, f_py};

    // pitch row
    logic                      p_valid [0:N];
    logic                      p_ready [0:N];
    logic signed [W-1:0]       p_x     [0:N];
    logic signed [W-1:0]       p_y     [0:N-1];
    logic signed [ANGLE_W-1:0] p_z     [0:N];
    logic [SPW-1:0]            p_side  [0:N];

    assign p_valid[0] = r_valid[N];
    assign r_ready[N] = p_ready[0];
    assign p_x[0]     = r_x[N];
    assign p_y[0]     = r_side[N][W-1:0];
    assign p_z[0]     = '0;
    assign p_side[0]  = {r_side[N][SRW-1:W], r_z[N]};

    for (genvar k = 0; k < N; k++)
    begin : g_cells
        if (k < N - 1)
        begin : g_mid
            atrp_cell #(
                .W (W), .AW (ANGLE_W), .SW (SRW),
                .SHIFT (k), .ATAN_STEP (atan_entry(k))
            ) u_roll (
                .clk (clk), .rst_n (rst_n),
                .in_valid (r_valid[k]), .in_ready (r_ready[k]),
                .in_x (r_x[k]), .in_y (r_y[k]), .in_z (r_z[k]), .in_side (r_side[k]),
                .out_valid (r_valid[k+1]), .out_ready (r_ready[k+1]),
                .out_x (r_x[k+1]), .out_y (r_y[k+1]), .out_z (r_z[k+1]),
                .out_side (r_side[k+1])
            );
            atrp_cell #(
                .W (W), .AW (ANGLE_W), .SW (SPW),
                .SHIFT (k), .ATAN_STEP (atan_entry(k))
            ) u_pitch (
                .clk (clk), .rst_n (rst_n),
                .in_valid (p_valid[k]), .in_ready (p_ready[k]),
                .in_x (p_x[k]), .in_y (p_y[k]), .in_z (p_z[k]), .in_side (p_side[k]),
                .out_valid (p_valid[k+1]), .out_ready (p_ready[k+1]),
                .out_x (p_x[k+1]), .out_y (p_y[k+1]), .out_z (p_z[k+1]),
                .out_side (p_side[k+1])
            );
        end
        else
        begin : g_last
            // final residual is not needed
            atrp_cell #(
                .W (W), .AW (ANGLE_W), .SW (SRW),
                .SHIFT (k), .ATAN_STEP (atan_entry(k))
            ) u_roll (
                .clk (clk), .rst_n (rst_n),
                .in_valid (r_valid[k]), .in_ready (r_ready[k]),
                .in_x (r_x[k]), .in_y (r_y[k]), .in_z (r_z[k]), .in_side (r_side[k]),
                .out_valid (r_valid[k+1]), .out_ready (r_ready[k+1]),
                .out_x (r_x[k+1]), .out_y (), .out_z (r_z[k+1]),
                .out_side (r_side[k+1])
            );
            atrp_cell #(
                .W (W), .AW (ANGLE_W), .SW (SPW),
                .SHIFT (k), .ATAN_STEP (atan_entry(k))
            ) u_pitch (
                .clk (clk), .rst_n (rst_n),
                .in_valid (p_valid[k]), .in_ready (p_ready[k]),
                .in_x (p_x[k]), .in_y (p_y[k]), .in_z (p_z[k]), .in_side (p_side[k]),
                .out_valid (p_valid[k+1]), .out_ready (p_ready[k+1]),
                .out_x (p_x[k+1]), .out_y (), .out_z (p_z[k+1]),
                .out_side (p_side[k+1])
            );
        end
    end

    // output stage: round half up to 1/128 degree, saturate, special cases
    atrp_flags_t               o_flags;
    logic signed [ANGLE_W-1:0] o_roll_acc;
    logic signed [ANGLE_W:0]   roll_sum, pitch_sum;
    logic signed [VW-1:0]      roll_v, pitch_v;
    logic signed [ROLL_W-1:0]  roll_next;
    logic signed [PITCH_W-1:0] pitch_next;

    logic                      out_valid_reg;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;

    assign o_flags    = p_side[N][SPW-1:ANGLE_W];
    assign o_roll_acc = p_side[N][ANGLE_W-1:0];

    always_comb
    begin
        roll_sum  = (ANGLE_W+1)'(o_roll_acc) + HALF_LSB;
        pitch_sum = (ANGLE_W+1)'(p_z[N]) + HALF_LSB;
        roll_v    = VW'(roll_sum >>> ROUND_SHIFT);
        pitch_v   = VW'(pitch_sum >>> ROUND_SHIFT);

        if (roll_v > ROLL_MAX)
            roll_next = ROLL_W'(ROLL_LIMIT);
        else if (roll_v < -ROLL_MAX)
            roll_next = -ROLL_W'(ROLL_LIMIT);
        else
            roll_next = ROLL_W'(roll_v);

        if (pitch_v > PITCH_MAX)
            pitch_next = PITCH_W'(PITCH_LIMIT);
        else if (pitch_v < -PITCH_MAX)
            pitch_next = -PITCH_W'(PITCH_LIMIT);
        else
            pitch_next = PITCH_W'(pitch_v);

        // y and z both zero: roll zero, pitch straight up or down, or zero when x is zero too
        if (o_flags.special)
        begin
            roll_next = '0;
            if (o_flags.x_pos)
                pitch_next = -PITCH_W'(PITCH_LIMIT);
            else if (o_flags.x_neg)
                pitch_next = PITCH_W'(PITCH_LIMIT);
            else
                pitch_next = '0;
        end
    end

    assign p_ready[N] = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (p_ready[N])
            out_valid_reg <= p_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (p_ready[N] && p_valid[N])
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, pitch_reg, roll_reg};

    // checks
    `ATRP_ASSERT_NOW(a_roll_range, clk, rst_n, m_tvalid,
        (roll_reg <= ROLL_W'(ROLL_LIMIT)) && (roll_reg >= -ROLL_W'(ROLL_LIMIT)))
    `ATRP_ASSERT_NOW(a_pitch_range, clk, rst_n, m_tvalid,
        (pitch_reg <= PITCH_W'(PITCH_LIMIT)) && (pitch_reg >= -PITCH_W'(PITCH_LIMIT)))
    `ATRP_ASSERT_NOW(a_radius_pos, clk, rst_n, p_valid[N] && !o_flags.special,
        !p_x[N][W-1])
    `ATRP_ASSERT_NEXT(a_special_roll, clk, rst_n,
        p_valid[N] && p_ready[N] && o_flags.special, roll_reg == '0)
    `ATRP_ASSERT_NOW(a_front_free, clk, rst_n, !f_valid, s_tready)

endmodule

### bench/tilt_checker.sv
`timescale 1ns / 100ps
// Checker for the tilt block: watches both channels, predicts roll and pitch, compares results.
module tilt_checker #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int IN_W          = ((3*SAMPLE_WIDTH+7)/8)*8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,    // accel_x, accel_y, accel_z from bit 0 up
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [31:0]     m_tdata,    // roll_angle [15:0], pitch_angle [30:16], pad [31]
    output int              errors,
    output int              pending,
    output int              checked
);

    localparam longint GUARD      = 65536;
    localparam longint GAIN       = 107922;   // CORDIC gain, Q16
    localparam longint RIGHT_ANG  = 2949120;  // 90 deg in 2^-15 deg
    localparam longint ROLL_MAX   = 23040;
    localparam longint PITCH_MAX  = 11520;
    localparam int     STEP_COUNT = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    typedef struct packed {
        logic        pad;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } tilt_t;

    tilt_t expected_tilt[$];

    // atan(2^-i), 2^-15 degree units
    function automatic longint atan_of_shift(input int i);
        case (i)
            0:  return 1474560;
            1:  return 870484;
            2:  return 459940;
            3:  return 233473;
            4:  return 117189;
            5:  return 58652;
            6:  return 29333;
            7:  return 14667;
            8:  return 7334;
            9:  return 3667;
            10: return 1833;
            11: return 917;
            12: return 458;
            13: return 229;
            14: return 115;
            15: return 57;
            16: return 29;
            17: return 14;
            18: return 7;
            19: return 4;
            20: return 2;
            21: return 1;
            default: return 0;
        endcase
    endfunction

    // vectoring rotation: drives vy to zero, returns the summed angle
    function automatic longint rotate_to_axis(input longint vx, input longint vy,
                                              input longint ang, output longint radius);
        longint dx;
        longint dy;
        for (int i = 0; i < STEP_COUNT; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + atan_of_shift(i);
            end
            else begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - atan_of_shift(i);
            end
        end
        radius = vx;
        return ang;
    endfunction

    function automatic longint to_angle(input longint acc, input longint limit);
        longint v;
        v = (acc + 128) >>> 8;
        if (v > limit)
            v = limit;
        if (v < -limit)
            v = -limit;
        return v;
    endfunction

    function automatic tilt_t predict_tilt(input logic [IN_W-1:0] w);
        logic signed [SAMPLE_WIDTH-1:0] fx;
        logic signed [SAMPLE_WIDTH-1:0] fy;
        logic signed [SAMPLE_WIDTH-1:0] fz;
        longint ax, ay, az, cx, cy, t, base, radius, spare, py, roll, pitch;
        tilt_t r;
        fx = w[SAMPLE_WIDTH-1:0];
        fy = w[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        fz = w[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
        ax = fx;
        ay = fy;
        az = fz;
        if (ay == 0 && az == 0) begin
            roll  = 0;
            pitch = (ax > 0) ? -PITCH_MAX : ((ax < 0) ? PITCH_MAX : 0);
        end
        else begin
            cx   = az * GUARD;
            cy   = ay * GUARD;
            base = 0;
            // left half-plane: quarter turn first
            if (cx < 0) begin
                t = cx;
                if (cy >= 0) begin
                    cx   = cy;
                    cy   = -t;
                    base = RIGHT_ANG;
                end
                else begin
                    cx   = -cy;
                    cy   = t;
                    base = -RIGHT_ANG;
                end
            end
            roll  = to_angle(rotate_to_axis(cx, cy, base, radius), ROLL_MAX);
            // -x carries the same gain as the radius
            py    = ((-(ax * GUARD)) * GAIN + 32768) >>> 16;
            pitch = to_angle(rotate_to_axis(radius, py, 0, spare), PITCH_MAX);
        end
        r.pad   = 1'b0;
        r.roll  = roll[15:0];
        r.pitch = pitch[14:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        tilt_t want;
        tilt_t got;
        if (rst_n && s_tvalid && s_tready)
            expected_tilt.push_back(predict_tilt(s_tdata));
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_tilt.size() == 0) begin
                $error("result word with nothing expected: roll %0d pitch %0d",
                       got.roll, got.pitch);
                errors++;
            end
            else begin
                want = expected_tilt.pop_front();
                checked++;
                if (got.roll !== want.roll) begin
                    $error("roll_angle: expected %0d, got %0d", want.roll, got.roll);
                    errors++;
                end
                if (got.pitch !== want.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d", want.pitch, got.pitch);
                    errors++;
                end
                if (got.pad !== want.pad) begin
                    $error("pad bit: expected %0d, got %0d", want.pad, got.pad);
                    errors++;
                end
            end
        end
        pending = expected_tilt.size();
    end

endmodule

### bench/accel_tilt_roll_pitch_test.sv
`timescale 1ns / 100ps
// Top of the tilt bench: clock, reset, sample stimulus, result back-pressure and verdict.
module accel_tilt_roll_pitch_test;

    localparam int SW        = 16;
    localparam int IN_W      = ((3*SW+7)/8)*8;
    localparam int N_ITEMS   = 1150;
    localparam int HOLD_LEN  = 400;     // long receiver stall, fills the pipe
    localparam int TAIL      = 40;      // quiet tail, outlasts the pipe at 16 stages
    localparam int LIMIT     = 200000;

    logic            clk;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;     // accel_x, accel_y, accel_z from bit 0 up
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [31:0]     m_tdata;           // roll_angle, pitch_angle, pad bit from bit 0 up

    int errors;
    int pending;
    int checked;
    int sent      = 0;
    int directed  = 0;
    int zero_yz   = 0;
    int got       = 0;
    int cycles    = 0;
    bit held      = 1'b0;

    accel_tilt_roll_pitch u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tilt_checker #(.SAMPLE_WIDTH(SW), .CORDIC_STAGES(16)) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one sample word; valid stays high into the next word when no gap is drawn.
    // Every 200 words the first 40 go back to back.
    task automatic send_sample(input logic [SW-1:0] x, input logic [SW-1:0] y,
                               input logic [SW-1:0] z);
        int gap;
        gap = ((sent % 200) < 40) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
        sent++;
        if (y == '0 && z == '0)
            zero_yz++;
    endtask

    function automatic logic [SW-1:0] small_val();
        return SW'($urandom_range(0, 6)) - SW'(3);
    endfunction

    function automatic logic [SW-1:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // near 1 g on one axis of either sign, a little noise on the rest
    function automatic logic [SW-1:0] gravity_val(input bit strong_axis);
        logic [SW-1:0] v;
        if (strong_axis) begin
            v = 16'd16384 + SW'($urandom_range(0, 2000)) - SW'(1000);
            return $urandom_range(0, 1) ? v : -v;
        end
        return SW'($urandom_range(0, 1600)) - SW'(800);
    endfunction

    task automatic send_random();
        logic [SW-1:0] x, y, z;
        int axis;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                x = SW'($urandom());
                y = SW'($urandom());
                z = SW'($urandom());
            end
            5:
            begin
                x = small_val();
                y = small_val();
                z = small_val();
            end
            6:
            begin
                // y and z both zero: pitch pinned to the poles or zero
                x = $urandom_range(0, 3) == 0 ? small_val() : SW'($urandom());
                y = '0;
                z = '0;
            end
            7:
            begin
                // one of y, z zero: axis crossings incl. the half-turn
                x = SW'($urandom());
                y = $urandom_range(0, 1) ? SW'($urandom()) : '0;
                z = (y == '0) ? SW'($urandom()) : '0;
            end
            8:
            begin
                x = edge_val();
                y = edge_val();
                z = edge_val();
            end
            default:
            begin
                axis = $urandom_range(0, 2);
                x = gravity_val(axis == 0);
                y = gravity_val(axis == 1);
                z = gravity_val(axis == 2);
            end
        endcase
        send_sample(x, y, z);
    endtask

    // Receiver: random gaps per word, a calm stretch every 250 words,
    // and one long hold-off while the sender keeps offering.
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && got >= 300) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                held = 1'b1;
            end
            gap = ((got % 250) >= 200) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got++;
        end
    end

    // Watchdog: generous against the slowest legal run.
    initial
    begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("accel_tilt_roll_pitch test failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: poles, axis crossings, half-turn, extremes, equal components.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0001, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF, 16'h8000);
        send_sample(16'h0000, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'd100, 16'd100);
        send_sample(16'h8000, 16'h0001, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0001);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'd16384, -16'sd16384, 16'd16384);
        send_sample(16'h0000, 16'd16384, -16'sd16384);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'd12345, 16'hFFFF, 16'h0000);
        send_sample(-16'sd5, 16'd3, 16'd4);
        directed = sent;

        while (sent < N_ITEMS)
            send_random();
        s_tvalid <= 1'b0;

        // drain, then a quiet tail to catch stray words
        do @(negedge clk); while (pending != 0);
        repeat (TAIL) @(posedge clk);
        @(negedge clk);

        $display("Covered %0d samples (%0d directed, %0d with y and z both zero); %0d results",
                 sent, directed, zero_yz, checked);
        $display("Both sides idled 0..5 cycles per word; receiver stalled %0d cycles once",
                 HOLD_LEN);
        if (errors == 0 && pending == 0)
            $display("accel_tilt_roll_pitch test passed");
        else
            $display("accel_tilt_roll_pitch test failed");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/atrp_pkg.sv
design/atrp_front.sv
design/atrp_cell.sv
design/accel_tilt_roll_pitch.sv
bench/tilt_checker.sv
bench/accel_tilt_roll_pitch_test.sv
